// ===== design/sobel_edge_magnitude_rgb_unit_assert.svh =====
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH

// assertion with explicit clock and active-low reset
`define SEMR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define SEMR_ASSERT(lbl, prop, msg) `SEMR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/sobel_pkg.sv =====
`default_nettype none

package sobel_pkg;

  localparam int MaxWidth    = 1024;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int CfgWidthW   = 11;
  localparam int CfgHeightW  = 12;
  localparam int CfgDataW    = 12;
  localparam int RowW        = CfgHeightW + 1;
  localparam int PosW        = 22;
  localparam int WhW         = CfgWidthW + CfgHeightW;
  localparam int DivCntW     = $clog2(PosW + 1);
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int ResetWidthV  = 640;
  localparam int ResetHeightV = 480;
  localparam logic [7:0] SatMax = 8'd255;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    pix_t            pix;
    logic            emit;
    logic            interior;
    logic            done;
  } cmd_t;

  function automatic logic [7:0] chan(pix_t p, logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = p[23:16];
      2'd1:    v = p[15:8];
      default: v = p[7:0];
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/sobel_front.sv =====
`default_nettype none

`include "sobel_edge_magnitude_rgb_unit_assert.svh"

module sobel_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sobel_pkg::in_item_t           in_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  sobel_pkg::cfg_index_e         cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          push_o,
  output sobel_pkg::cmd_t               push_data_o,
  input  logic                          full_i
);
  import sobel_pkg::*;

  logic [CfgWidthW-1:0]  w_q, w_eff;
  logic [CfgHeightW-1:0] h_q, h_eff;
  logic [WhW-1:0]        wh_q, wh_d;

  logic [ColW-1:0]    col_q, col_d, c;
  logic [RowW-1:0]    row_q, row_d, r, h1;
  logic [PosW-1:0]    opos_q, opos_d, orow_q, orow_d;
  logic [ColW-1:0]    ocol_q, ocol_d;
  logic               busy_q, busy_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [PosW-1:0]    div_num_q, div_num_d;
  logic [ColW-1:0]    div_rem_q, div_rem_d;
  logic [CfgWidthW-1:0] rem_t, rem_s;

  logic accept, cfg_acc, live, ignore, emit, c_last, interior, done, o_last, qbit;
  pix_t pix;

  assign in_ready_o  = !busy_q && !full_i;
  assign cfg_ready_o = !busy_q;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    w_eff = w_q;
    if (w_q == '0) begin
      w_eff = CfgWidthW'(1);
    end else if (w_q > CfgWidthW'(MaxWidth)) begin
      w_eff = CfgWidthW'(MaxWidth);
    end
    h_eff = (h_q == '0) ? CfgHeightW'(1) : h_q;
    wh_d  = {{(WhW-CfgWidthW){1'b0}}, w_eff} * {{(WhW-CfgHeightW){1'b0}}, h_eff};
  end

  always_comb begin
    c        = ({1'b0, col_q} < w_eff) ? col_q : '0;
    h1       = {1'b0, h_eff} + RowW'(1);
    r        = (row_q > h1) ? h1 : row_q;
    live     = r < {1'b0, h_eff};
    ignore   = live && in_data_i.opcode;
    pix      = live ? {in_data_i.red, in_data_i.green, in_data_i.blue} : '0;
    emit     = (r != '0) && !((r == RowW'(1)) && (c == '0));
    c_last   = ({1'b0, c} + CfgWidthW'(1)) >= w_eff;
    interior = (orow_q != '0)
               && (({1'b0, orow_q} + (PosW+1)'(2)) <= (PosW+1)'(h_eff))
               && (ocol_q != '0)
               && (({2'b0, ocol_q} + (ColW+2)'(2)) <= {1'b0, w_eff});
    done     = ({1'b0, opos_q} + (PosW+1)'(1)) >= wh_q;
    o_last   = ({1'b0, ocol_q} + CfgWidthW'(1)) >= w_eff;
  end

  always_comb begin
    rem_t = {div_rem_q, div_num_q[PosW-1]};
    qbit  = rem_t >= w_eff;
    rem_s = qbit ? (rem_t - w_eff) : rem_t;
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    opos_d    = opos_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    busy_d    = busy_q;
    div_cnt_d = div_cnt_q;
    div_num_d = div_num_q;
    div_rem_d = div_rem_q;
    if (accept) begin
      col_d = c;
      row_d = r;
      if (!ignore) begin
        if (c_last) begin
          col_d = '0;
          if (r <= {1'b0, h_eff}) begin
            row_d = r + RowW'(1);
          end
        end else begin
          col_d = c + ColW'(1);
        end
        if (emit) begin
          if (done) begin
            col_d  = '0;
            row_d  = '0;
            opos_d = '0;
            orow_d = '0;
            ocol_d = '0;
          end else begin
            opos_d = opos_q + PosW'(1);
            if (o_last) begin
              ocol_d = '0;
              orow_d = orow_q + PosW'(1);
            end else begin
              ocol_d = ocol_q + ColW'(1);
            end
          end
        end
      end
    end
    // restore row and column of the output position after a cfg transfer
    if (busy_q) begin
      div_rem_d = rem_s[ColW-1:0];
      div_num_d = {div_num_q[PosW-2:0], qbit};
      div_cnt_d = div_cnt_q - DivCntW'(1);
      if (div_cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        orow_d = {div_num_q[PosW-2:0], qbit};
        ocol_d = rem_s[ColW-1:0];
      end
    end
    if (cfg_acc) begin
      busy_d    = 1'b1;
      div_cnt_d = DivCntW'(PosW);
      div_num_d = opos_q;
      div_rem_d = '0;
    end
  end

  assign push_o      = accept && !ignore;
  assign push_data_o = '{col: c, pix: pix, emit: emit, interior: interior, done: done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= CfgWidthW'(ResetWidthV);
      h_q  <= CfgHeightW'(ResetHeightV);
      wh_q <= WhW'(ResetWidthV * ResetHeightV);
    end else begin
      wh_q <= wh_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          CFG_FRAME_WIDTH:  w_q <= cfg_data_i[CfgWidthW-1:0];
          CFG_FRAME_HEIGHT: h_q <= cfg_data_i[CfgHeightW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      opos_q    <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      busy_q    <= 1'b0;
      div_cnt_q <= '0;
      div_num_q <= '0;
      div_rem_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      opos_q    <= opos_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      busy_q    <= busy_d;
      div_cnt_q <= div_cnt_d;
      div_num_q <= div_num_d;
      div_rem_q <= div_rem_d;
    end
  end

  `SEMR_ASSERT(a_ocol_in_row, !busy_q |-> ({1'b0, ocol_q} < w_eff), "output column past width")

endmodule

`default_nettype wire

// ===== design/sobel_fifo.sv =====
`default_nettype none

`include "sobel_edge_magnitude_rgb_unit_assert.svh"

module sobel_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sobel_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sobel_pkg::cmd_t head_o
);
  import sobel_pkg::*;

  cmd_t             ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = cnt_q == (QPtrW+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  `SEMR_ASSERT(a_q_bounds, (push_i |-> !full_o) and (pop_i |-> !empty_o), "queue over or underrun")

endmodule

`default_nettype wire

// ===== design/sobel_back.sv =====
`default_nettype none

`include "sobel_edge_magnitude_rgb_unit_assert.svh"

module sobel_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  sobel_pkg::cmd_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sobel_pkg::out_item_t out_data_o
);
  import sobel_pkg::*;

  localparam int RootSteps = 11;
  localparam int CntW      = $clog2(RootSteps);
  localparam logic [10:0] RootMax = 11'd1443;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SQ   = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  pix_t up_mem  [MaxWidth];
  pix_t up2_mem [MaxWidth];
  pix_t rd1_q, rd2_q;
  pix_t win_q [3][3];
  cmd_t cmd_q;

  logic [9:0]  agx_q [3], agy_q [3];
  logic [9:0]  gxp [3], gxn [3], gyp [3], gyn [3], agx [3], agy [3];
  logic [19:0] sqx [3], sqy [3];
  logic [21:0] rad_q [3];
  logic [10:0] root_q [3], root_n [3];
  logic [11:0] rem_q [3], rem_n [3];
  logic [13:0] t [3], trial [3], diff [3];
  logic [11:0] rnd [3];
  logic [7:0]  val [3];
  logic [CntW-1:0] cnt_q;
  logic        out_valid_q, load_out;
  out_item_t   out_q;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_RD;
      ST_RD:   state_d = cmd_q.emit ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQ;
      ST_SQ:   state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == '0) state_d = ST_OUT;
      ST_OUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gxp[k] = {2'b0, chan(win_q[0][2], 2'(k))} + {1'b0, chan(win_q[1][2], 2'(k)), 1'b0}
               + {2'b0, chan(win_q[2][2], 2'(k))};
      gxn[k] = {2'b0, chan(win_q[0][0], 2'(k))} + {1'b0, chan(win_q[1][0], 2'(k)), 1'b0}
               + {2'b0, chan(win_q[2][0], 2'(k))};
      gyp[k] = {2'b0, chan(win_q[2][0], 2'(k))} + {1'b0, chan(win_q[2][1], 2'(k)), 1'b0}
               + {2'b0, chan(win_q[2][2], 2'(k))};
      gyn[k] = {2'b0, chan(win_q[0][0], 2'(k))} + {1'b0, chan(win_q[0][1], 2'(k)), 1'b0}
               + {2'b0, chan(win_q[0][2], 2'(k))};
      agx[k] = (gxp[k] >= gxn[k]) ? (gxp[k] - gxn[k]) : (gxn[k] - gxp[k]);
      agy[k] = (gyp[k] >= gyn[k]) ? (gyp[k] - gyn[k]) : (gyn[k] - gyp[k]);
      sqx[k] = {10'd0, agx_q[k]} * {10'd0, agx_q[k]};
      sqy[k] = {10'd0, agy_q[k]} * {10'd0, agy_q[k]};
      // one result bit per step
      t[k]      = {rem_q[k], rad_q[k][21:20]};
      trial[k]  = {1'b0, root_q[k], 2'b01};
      diff[k]   = t[k] - trial[k];
      rem_n[k]  = (t[k] >= trial[k]) ? diff[k][11:0] : t[k][11:0];
      root_n[k] = {root_q[k][9:0], t[k] >= trial[k]};
      rnd[k]    = {1'b0, root_q[k]} + {11'd0, rem_q[k] > {1'b0, root_q[k]}};
      val[k]    = cmd_q.interior ? ((rnd[k] > {4'd0, SatMax}) ? SatMax : rnd[k][7:0])
                                 : chan(win_q[1][1], 2'(k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd1_q <= up_mem[head_i.col];
      rd2_q <= up2_mem[head_i.col];
    end
    if (state_q == ST_RD) begin
      up_mem[cmd_q.col]  <= cmd_q.pix;
      up2_mem[cmd_q.col] <= rd1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    for (int k = 0; k < 3; k++) begin
      if (state_q == ST_GRAD) begin
        agx_q[k] <= agx[k];
        agy_q[k] <= agy[k];
      end
      if (state_q == ST_SQ) begin
        rad_q[k]  <= {1'b0, {1'b0, sqx[k]} + {1'b0, sqy[k]}};
        root_q[k] <= '0;
        rem_q[k]  <= '0;
      end else if (state_q == ST_ROOT) begin
        rad_q[k]  <= {rad_q[k][19:0], 2'b00};
        root_q[k] <= root_n[k];
        rem_q[k]  <= rem_n[k];
      end
    end
    if (state_q == ST_SQ) begin
      cnt_q <= CntW'(RootSteps - 1);
    end else if (state_q == ST_ROOT) begin
      cnt_q <= cnt_q - CntW'(1);
    end
    if (load_out) begin
      out_q <= '{out_red: val[0], out_green: val[1], out_blue: val[2],
                 frame_done: cmd_q.done};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_RD) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= rd2_q;
        win_q[1][2] <= rd1_q;
        win_q[2][2] <= cmd_q.pix;
      end
    end
  end

  `SEMR_ASSERT(a_root_range, (state_q == ST_OUT) |-> (root_q[0] <= RootMax && root_q[1] <= RootMax && root_q[2] <= RootMax), "root out of range")

endmodule

`default_nettype wire

// ===== design/sobel_edge_magnitude_rgb_unit.sv =====
// channel | dir | signals
// in      | in  | in_valid_i / in_ready_o, in_data_i (opcode, red, green, blue)
// out     | out | out_valid_o / out_ready_i, out_data_o (out_red .. frame_done)
// cfg     | in  | cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
//
// the front takes one item per cycle into a two-entry queue unless it is full
// or busy after a cfg transfer; the back takes an item only when done with the
// last (line buffer read alone for no result; for a result: line buffer read,
// gradient, squares, 11-step square root, output); after reset: 640 x 480; each
// cfg transfer blocks in and cfg while the output row and column are recomputed
// a stalled output holds the back in its last step, the front runs until the
// queue is full
`default_nettype none

module sobel_edge_magnitude_rgb_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sobel_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sobel_pkg::out_item_t           out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  sobel_pkg::cfg_index_e          cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0] cfg_data_i
);
  import sobel_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_data, head;

  sobel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sobel_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  sobel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
